// ===== design/dmdc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dmdc_pkg
// Shared types and constants for the direct-mapped write-through data cache:
// geometry of the line store, tag store and backing memory, request kinds,
// sequencer states and register indexes.
// ----------------------------------------------------------------------------
package dmdc_pkg;

   // geometry
   localparam int MAX_BLOCK_WORDS = 16;
   localparam int MAX_LINES       = 256;
   localparam int MEM_WORDS       = 16384;

   localparam int ADDR_W   = 16;
   localparam int DATA_W   = 32;
   localparam int CNT_W    = 32;
   localparam int WADDR_W  = ADDR_W - 2;
   localparam int BACK_AW  = $clog2(MEM_WORDS);
   localparam int WSEL_W   = $clog2(MAX_BLOCK_WORDS);
   localparam int WSEL_W1  = WSEL_W + 1;
   localparam int IDX_W    = $clog2(MAX_LINES);
   localparam int IDX_W1   = IDX_W + 1;
   localparam int LINE_AW  = IDX_W + WSEL_W;
   localparam int TAG_W    = WADDR_W;
   localparam int SHIFT_W  = 5;

   // configuration registers
   localparam int BW_CFG_W   = 3;
   localparam int LC_CFG_W   = 4;
   localparam int PADDR_W    = 3;
   localparam logic [BW_CFG_W-1:0] BW_RESET   = 3'd2;
   localparam logic [LC_CFG_W-1:0] LC_RESET   = 4'd6;
   localparam logic [BW_CFG_W-1:0] BW_LOG_MAX = BW_CFG_W'(WSEL_W);
   localparam logic [LC_CFG_W-1:0] LC_LOG_MAX = LC_CFG_W'(IDX_W);

   // lane masks
   localparam logic [DATA_W-1:0] SIGN_FILL = 32'hFFFF_FF00;
   localparam logic [DATA_W-1:0] BYTE_MASK = 32'h0000_00FF;
   localparam logic [DATA_W-1:0] HALF_MASK = 32'h0000_FFFF;

   typedef enum logic [2:0] {
      KIND_RD_BYTE_S = 3'd0,
      KIND_RD_BYTE_U = 3'd1,
      KIND_RD_HALF   = 3'd2,
      KIND_RD_WORD   = 3'd3,
      KIND_WR_BYTE   = 3'd4,
      KIND_WR_HALF   = 3'd5,
      KIND_WR_WORD   = 3'd6,
      KIND_PRELOAD   = 3'd7
   } kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_FILL,
      ST_ACCESS
   } state_type;

   typedef enum logic {
      CSR_BLOCK_WORDS = 1'b0,
      CSR_LINE_COUNT  = 1'b1
   } csr_index_type;

endpackage
`default_nettype wire

// ===== design/direct_mapped_data_cache_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// direct_mapped_data_cache_unit
// Direct-mapped write-through data cache with its own word-addressed backing
// memory. Line words, tags and backing words live in single-port synchronous
// memories; a small sequencer reads, merges and writes them back.
// ----------------------------------------------------------------------------
// After reset the unit sweeps the line store to zero, one word per cycle,
// with busy high; register writes are taken during the sweep.
// A request is taken when start is high and busy is low, and its word shows
// on the rsp_ ports for exactly one cycle, marked by rsp_valid, which the
// receiver must take as it comes. A preload leaves busy low. A hit reads
// the tag and line stores, then compares and merges. A miss runs a line
// fill that moves one backing word per cycle through the single backing
// memory port, then the access. The result appears in the cycle after the
// last cycle of the request, when busy is already low again.
// ----------------------------------------------------------------------------
module direct_mapped_data_cache_unit
   import dmdc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // request
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [2:0]          req_kind,
   input  wire logic [ADDR_W-1:0]   req_address,
   input  wire logic [DATA_W-1:0]   req_write_data,
   // result
   output logic                     rsp_valid,
   output logic [DATA_W-1:0]        rsp_read_data,
   output logic                     rsp_hit,
   output logic [CNT_W-1:0]         rsp_access_count,
   output logic [CNT_W-1:0]         rsp_hit_count,
   // register port
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [PADDR_W-1:0]  paddr,
   input  wire logic [DATA_W-1:0]   pwdata,
   output logic [DATA_W-1:0]        prdata,
   output logic                     pready
);

   // memories
   logic [TAG_W-1:0]  tag_mem  [MAX_LINES];
   logic [DATA_W-1:0] line_mem [MAX_LINES * MAX_BLOCK_WORDS];
   logic [DATA_W-1:0] back_mem [MEM_WORDS];

   // control state
   state_type             state_ff, state_in;
   logic [BW_CFG_W-1:0]   cfg_bw_ff;
   logic [LC_CFG_W-1:0]   cfg_lc_ff;
   logic [MAX_LINES-1:0]  valid_ff;
   logic [LINE_AW-1:0]    clr_cnt_ff, clr_cnt_in;
   logic [WSEL_W:0]       issue_cnt_ff, issue_cnt_in;
   logic                  wr_pend_ff, wr_pend_in;
   logic [WSEL_W-1:0]     wr_cnt_ff, wr_cnt_in;
   logic [CNT_W-1:0]      access_cnt_ff, access_cnt_in;
   logic [CNT_W-1:0]      hit_cnt_ff, hit_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // payload state
   kind_type              kind_ff;
   logic [1:0]            off_ff;
   logic [WADDR_W-1:0]    wa_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [TAG_W-1:0]      tag_ff;
   logic [WSEL_W-1:0]     wsel_ff;
   logic [DATA_W-1:0]     wdata_ff;
   logic [DATA_W-1:0]     cur_ff, cur_in;
   logic [TAG_W-1:0]      tag_rd_ff;
   logic [DATA_W-1:0]     line_rd_ff;
   logic [DATA_W-1:0]     back_rd_ff;
   logic [DATA_W-1:0]     rsp_read_data_ff, rsp_read_data_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [CNT_W-1:0]      rsp_access_count_ff;
   logic [CNT_W-1:0]      rsp_hit_count_ff;

   // memory controls
   logic                  tag_we, tag_re;
   logic [IDX_W-1:0]      tag_addr;
   logic                  line_we, line_re;
   logic [LINE_AW-1:0]    line_addr;
   logic [DATA_W-1:0]     line_wdata;
   logic                  back_we, back_re;
   logic [BACK_AW-1:0]    back_addr;
   logic [DATA_W-1:0]     back_wdata;
   logic                  valid_set;

   // request decode
   logic                  accept;
   logic                  cfg_write;
   kind_type              kind_req;
   logic [BW_CFG_W-1:0]   bw_use;
   logic [LC_CFG_W-1:0]   lc_use;
   logic [WSEL_W-1:0]     bw_mask;
   logic [IDX_W-1:0]      lc_mask;
   logic [WSEL_W:0]       line_len;
   logic [WADDR_W-1:0]    wa_req;
   logic [WADDR_W-1:0]    wa_shift;
   logic [IDX_W-1:0]      idx_req;
   logic [TAG_W-1:0]      tag_req;
   logic [WSEL_W-1:0]     wsel_req;
   logic [SHIFT_W-1:0]    tag_shift;

   // lookup and merge
   logic                  hit;
   logic                  is_write;
   logic                  fill_issue;
   logic                  fill_done;
   logic [WADDR_W-1:0]    fill_addr;
   logic [DATA_W-1:0]     cur_sel;
   logic [SHIFT_W-1:0]    sh_byte;
   logic [SHIFT_W-1:0]    sh_half;
   logic [DATA_W-1:0]     op_rdata;
   logic [DATA_W-1:0]     op_word;

   // handshakes
   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign cfg_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign kind_req  = kind_type'(req_kind);

   // register read
   always_comb begin
      case (csr_index_type'(paddr[2]))
         CSR_BLOCK_WORDS: prdata = {{(DATA_W-BW_CFG_W){1'b0}}, cfg_bw_ff};
         CSR_LINE_COUNT:  prdata = {{(DATA_W-LC_CFG_W){1'b0}}, cfg_lc_ff};
         default:         prdata = '0;
      endcase
   end

   // effective geometry, oversized settings saturate
   assign bw_use   = (cfg_bw_ff > BW_LOG_MAX) ? BW_LOG_MAX : cfg_bw_ff;
   assign lc_use   = (cfg_lc_ff > LC_LOG_MAX) ? LC_LOG_MAX : cfg_lc_ff;
   assign bw_mask  = WSEL_W'((WSEL_W1'(1) << bw_use) - WSEL_W1'(1));
   assign lc_mask  = IDX_W'((IDX_W1'(1) << lc_use) - IDX_W1'(1));
   assign line_len = WSEL_W1'(1) << bw_use;

   // address split of the incoming request
   assign wa_req    = req_address[ADDR_W-1:2];
   assign wa_shift  = wa_req >> bw_use;
   assign idx_req   = wa_shift[IDX_W-1:0] & lc_mask;
   assign tag_shift = SHIFT_W'(bw_use) + SHIFT_W'(lc_use);
   assign tag_req   = TAG_W'(wa_req >> tag_shift);
   assign wsel_req  = wa_req[WSEL_W-1:0] & bw_mask;

   // tag compare
   assign hit      = valid_ff[idx_ff] && (tag_rd_ff == tag_ff);
   assign is_write = (kind_ff inside {KIND_WR_BYTE, KIND_WR_HALF, KIND_WR_WORD});

   // line fill progress
   assign fill_issue = (issue_cnt_ff < line_len);
   assign fill_done  = !fill_issue && !wr_pend_ff;
   assign fill_addr  = (wa_ff & ~{{(WADDR_W-WSEL_W){1'b0}}, bw_mask})
                     | {{(WADDR_W-WSEL_W){1'b0}}, issue_cnt_ff[WSEL_W-1:0]};

   // lane extract and merge on the selected word
   assign cur_sel = (state_ff == ST_LOOKUP) ? line_rd_ff : cur_ff;
   assign sh_byte = {off_ff, 3'b000};
   assign sh_half = {off_ff[1], 4'b0000};

   always_comb begin
      op_rdata = '0;
      op_word  = cur_sel;
      case (kind_ff)
         KIND_RD_BYTE_S: begin
            op_rdata = (cur_sel >> sh_byte) & BYTE_MASK;
            if (op_rdata[7]) begin
               op_rdata = op_rdata | SIGN_FILL;
            end
         end
         KIND_RD_BYTE_U: op_rdata = (cur_sel >> sh_byte) & BYTE_MASK;
         KIND_RD_HALF:   op_rdata = (cur_sel >> sh_half) & HALF_MASK;
         KIND_RD_WORD:   op_rdata = cur_sel;
         KIND_WR_BYTE: begin
            op_word = (cur_sel & ~(BYTE_MASK << sh_byte))
                    | ((wdata_ff & BYTE_MASK) << sh_byte);
         end
         KIND_WR_HALF: begin
            op_word = (cur_sel & ~(HALF_MASK << sh_half))
                    | ((wdata_ff & HALF_MASK) << sh_half);
         end
         KIND_WR_WORD:   op_word = wdata_ff;
         default:        op_word = cur_sel;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == {LINE_AW{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && (kind_req != KIND_PRELOAD)) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = hit ? ST_IDLE : ST_FILL;
         end
         ST_FILL: begin
            if (fill_done) begin
               state_in = ST_ACCESS;
            end
         end
         ST_ACCESS: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // memory controls, counters and result word
   always_comb begin
      tag_we           = 1'b0;
      tag_re           = 1'b0;
      tag_addr         = idx_ff;
      line_we          = 1'b0;
      line_re          = 1'b0;
      line_addr        = {idx_ff, wsel_ff};
      line_wdata       = op_word;
      back_we          = 1'b0;
      back_re          = 1'b0;
      back_addr        = wa_ff[BACK_AW-1:0];
      back_wdata       = op_word;
      valid_set        = 1'b0;
      clr_cnt_in       = clr_cnt_ff;
      issue_cnt_in     = issue_cnt_ff;
      wr_pend_in       = wr_pend_ff;
      wr_cnt_in        = wr_cnt_ff;
      cur_in           = cur_ff;
      access_cnt_in    = access_cnt_ff;
      hit_cnt_in       = hit_cnt_ff;
      rsp_valid_in     = 1'b0;
      rsp_read_data_in = '0;
      rsp_hit_in       = 1'b0;
      case (state_ff)
         // zero the line store after reset
         ST_CLEAR: begin
            line_we    = 1'b1;
            line_addr  = clr_cnt_ff;
            line_wdata = '0;
            clr_cnt_in = clr_cnt_ff + LINE_AW'(1);
         end
         // preload goes straight to backing memory, else start the lookup
         ST_IDLE: begin
            if (accept) begin
               if (kind_req == KIND_PRELOAD) begin
                  back_we      = 1'b1;
                  back_addr    = wa_req[BACK_AW-1:0];
                  back_wdata   = req_write_data;
                  rsp_valid_in = 1'b1;
               end else begin
                  tag_re    = 1'b1;
                  tag_addr  = idx_req;
                  line_re   = 1'b1;
                  line_addr = {idx_req, wsel_req};
               end
            end
         end
         // hit finishes here, miss claims the line and starts the fill
         ST_LOOKUP: begin
            access_cnt_in = access_cnt_ff + CNT_W'(1);
            if (hit) begin
               hit_cnt_in       = hit_cnt_ff + CNT_W'(1);
               line_we          = is_write;
               back_we          = is_write;
               rsp_valid_in     = 1'b1;
               rsp_read_data_in = op_rdata;
               rsp_hit_in       = 1'b1;
            end else begin
               tag_we       = 1'b1;
               valid_set    = 1'b1;
               issue_cnt_in = '0;
               wr_pend_in   = 1'b0;
            end
         end
         // read one backing word a cycle, write the registered word into the line store
         ST_FILL: begin
            back_addr = fill_addr[BACK_AW-1:0];
            back_re   = fill_issue;
            if (fill_issue) begin
               issue_cnt_in = issue_cnt_ff + WSEL_W1'(1);
            end
            wr_pend_in = fill_issue;
            wr_cnt_in  = issue_cnt_ff[WSEL_W-1:0];
            if (wr_pend_ff) begin
               line_we    = 1'b1;
               line_addr  = {idx_ff, wr_cnt_ff};
               line_wdata = back_rd_ff;
               if (wr_cnt_ff == wsel_ff) begin
                  cur_in = back_rd_ff;
               end
            end
         end
         // access on the freshly filled word
         ST_ACCESS: begin
            line_we          = is_write;
            back_we          = is_write;
            rsp_valid_in     = 1'b1;
            rsp_read_data_in = op_rdata;
         end
         default: begin
            clr_cnt_in = clr_cnt_ff;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cfg_bw_ff     <= BW_RESET;
         cfg_lc_ff     <= LC_RESET;
         valid_ff      <= '0;
         clr_cnt_ff    <= '0;
         issue_cnt_ff  <= '0;
         wr_pend_ff    <= 1'b0;
         wr_cnt_ff     <= '0;
         access_cnt_ff <= '0;
         hit_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         issue_cnt_ff  <= issue_cnt_in;
         wr_pend_ff    <= wr_pend_in;
         wr_cnt_ff     <= wr_cnt_in;
         access_cnt_ff <= access_cnt_in;
         hit_cnt_ff    <= hit_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (valid_set) begin
            valid_ff[idx_ff] <= 1'b1;
         end
         if (cfg_write) begin
            case (csr_index_type'(paddr[2]))
               CSR_BLOCK_WORDS: cfg_bw_ff <= pwdata[BW_CFG_W-1:0];
               CSR_LINE_COUNT:  cfg_lc_ff <= pwdata[LC_CFG_W-1:0];
               default:         cfg_bw_ff <= cfg_bw_ff;
            endcase
         end
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= kind_req;
         off_ff   <= req_address[1:0];
         wa_ff    <= wa_req;
         idx_ff   <= idx_req;
         tag_ff   <= tag_req;
         wsel_ff  <= wsel_req;
         wdata_ff <= req_write_data;
      end
      cur_ff <= cur_in;
   end

   // result word
   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_read_data_ff    <= rsp_read_data_in;
         rsp_hit_ff          <= rsp_hit_in;
         rsp_access_count_ff <= access_cnt_in;
         rsp_hit_count_ff    <= hit_cnt_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_read_data_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_access_count = rsp_access_count_ff;
   assign rsp_hit_count    = rsp_hit_count_ff;

   // tag store
   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[tag_addr] <= tag_ff;
      end
      if (tag_re) begin
         tag_rd_ff <= tag_mem[tag_addr];
      end
   end

   // line store
   always_ff @(posedge clock) begin
      if (line_we) begin
         line_mem[line_addr] <= line_wdata;
      end
      if (line_re) begin
         line_rd_ff <= line_mem[line_addr];
      end
   end

   // backing memory
   always_ff @(posedge clock) begin
      if (back_we) begin
         back_mem[back_addr] <= back_wdata;
      end
      if (back_re) begin
         back_rd_ff <= back_mem[back_addr];
      end
   end

endmodule
`default_nettype wire
